### rtl/pst_pkg.sv
// shared types, codes and constants of the packed slot table
package pst_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam logic [31:0] NULL_ENTITY = 32'hFFFF_FFFF;
  localparam logic [31:0] DUMMY_RESET = 32'h47C3_5000;
  localparam logic [31:0] ZERO_WORD = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_ASSIGN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_MOVE,
    ST_FREE_PARK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] entity;
    logic [31:0] x;
    logic [31:0] z;
    logic [31:0] height;
    logic [31:0] rotation;
    logic [7:0]  faction;
  } record_t;

  localparam record_t RESET_RECORD = '{
    entity:   NULL_ENTITY,
    x:        DUMMY_RESET,
    z:        DUMMY_RESET,
    height:   ZERO_WORD,
    rotation: ZERO_WORD,
    faction:  8'h00
  };

endpackage

### rtl/pst_mem.sv
// record memory: one write port, one read port with registered read data
module pst_mem #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF,
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IW-1:0]    rd_addr,
  output pst_pkg::record_t rd_data,
  input  logic             wr_en,
  input  logic [IW-1:0]    wr_addr,
  input  pst_pkg::record_t wr_data
);

  pst_pkg::record_t mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/pst_ctrl.sv
// sequencer: clearing pass, entity scan, swap-remove and result register
module pst_ctrl #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF,
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int CW = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       op,
  input  logic [31:0]      entity_id,
  input  logic [11:0]      slot_index,
  input  logic [31:0]      pos_x,
  input  logic [31:0]      pos_z,
  input  logic [7:0]       faction_code,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [9:0]       result_slot,
  output logic             moved_valid,
  output logic [31:0]      moved_entity,
  output logic [10:0]      active_entries,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output logic             rd_en,
  output logic [IW-1:0]    rd_addr,
  input  pst_pkg::record_t rd_data,
  output logic             wr_en,
  output logic [IW-1:0]    wr_addr,
  output pst_pkg::record_t wr_data
);

  pst_pkg::state_t state, state_next;

  logic [IW-1:0]   clr_idx;
  logic [CW-1:0]   count;
  logic [CW-1:0]   scan_idx;
  logic            cmp_valid;
  logic [IW-1:0]   cmp_idx;
  logic [IW-1:0]   hit_idx;
  logic [IW-1:0]   last_idx;
  logic [31:0]     dummy;

  pst_pkg::op_t    req_op;
  logic [31:0]     req_ent;
  logic [11:0]     req_sidx;
  logic [31:0]     req_x;
  logic [31:0]     req_z;
  logic [7:0]      req_fac;

  pst_pkg::status_t res_status;
  logic [IW-1:0]   res_slot;
  logic            res_moved;
  logic [31:0]     res_ent;

  logic hit;
  logic scan_more;
  logic table_full;
  logic sidx_ok;
  logic out_free;

  assign hit        = cmp_valid && (rd_data.entity == req_ent);
  assign scan_more  = scan_idx < count;
  assign table_full = 32'(count) >= SLOT_COUNT;
  assign sidx_ok    = 32'(req_sidx) < SLOT_COUNT;
  assign out_free   = !out_valid || out_ready;
  assign cfg_ready  = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pst_pkg::ST_CLEAR: begin
        if (32'(clr_idx) == SLOT_COUNT - 1) state_next = pst_pkg::ST_IDLE;
      end
      pst_pkg::ST_IDLE: begin
        if (in_valid) state_next = pst_pkg::ST_EXEC;
      end
      pst_pkg::ST_EXEC: begin
        if (req_op == pst_pkg::OP_FREE || req_op == pst_pkg::OP_LOOKUP) begin
          state_next = pst_pkg::ST_SCAN;
        end else begin
          state_next = pst_pkg::ST_DONE;
        end
      end
      pst_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = (req_op == pst_pkg::OP_FREE) ? pst_pkg::ST_FREE_RD
                                                    : pst_pkg::ST_DONE;
        end else if (!scan_more && !cmp_valid) begin
          state_next = pst_pkg::ST_DONE;
        end
      end
      pst_pkg::ST_FREE_RD:   state_next = pst_pkg::ST_FREE_MOVE;
      pst_pkg::ST_FREE_MOVE: state_next = pst_pkg::ST_FREE_PARK;
      pst_pkg::ST_FREE_PARK: state_next = pst_pkg::ST_DONE;
      pst_pkg::ST_DONE: begin
        if (out_free) state_next = pst_pkg::ST_IDLE;
      end
      default: state_next = pst_pkg::ST_CLEAR;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = IW'(scan_idx);
    wr_en    = 1'b0;
    wr_addr  = clr_idx;
    wr_data  = pst_pkg::RESET_RECORD;
    unique case (state)
      pst_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
      end
      pst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      pst_pkg::ST_EXEC: begin
        wr_data = '{entity: req_ent, x: req_x, z: req_z, height: pst_pkg::ZERO_WORD,
                    rotation: pst_pkg::ZERO_WORD, faction: req_fac};
        if (req_op == pst_pkg::OP_ALLOC) begin
          wr_en   = !table_full;
          wr_addr = IW'(count);
        end else if (req_op == pst_pkg::OP_ASSIGN) begin
          wr_en   = sidx_ok;
          wr_addr = IW'(req_sidx);
        end
      end
      pst_pkg::ST_SCAN: begin
        rd_en = !hit && scan_more;
      end
      pst_pkg::ST_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx;
      end
      pst_pkg::ST_FREE_MOVE: begin
        wr_en   = hit_idx != last_idx;
        wr_addr = hit_idx;
        wr_data = rd_data;
      end
      pst_pkg::ST_FREE_PARK: begin
        wr_en   = 1'b1;
        wr_addr = last_idx;
        wr_data = '{entity: pst_pkg::NULL_ENTITY, x: dummy, z: dummy,
                    height: rd_data.height, rotation: rd_data.rotation,
                    faction: rd_data.faction};
      end
      pst_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pst_pkg::ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
      dummy     <= pst_pkg::DUMMY_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) dummy <= cfg_data;
      if (state == pst_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pst_pkg::ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        pst_pkg::ST_EXEC: begin
          cmp_valid <= 1'b0;
          if (req_op == pst_pkg::OP_ALLOC && !table_full) begin
            count <= count + 1'b1;
          end else if (req_op == pst_pkg::OP_ASSIGN && sidx_ok &&
                       32'(req_sidx) >= 32'(count)) begin
            count <= CW'(req_sidx) + 1'b1;
          end
        end
        pst_pkg::ST_SCAN: begin
          if (hit) begin
            cmp_valid <= 1'b0;
          end else if (scan_more) begin
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
        end
        pst_pkg::ST_FREE_PARK: count <= count - 1'b1;
        default: begin
        end
      endcase
    end
  end

  // request, scan and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      pst_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_op   <= pst_pkg::op_t'(op);
          req_ent  <= entity_id;
          req_sidx <= slot_index;
          req_x    <= pos_x;
          req_z    <= pos_z;
          req_fac  <= faction_code;
        end
      end
      pst_pkg::ST_EXEC: begin
        scan_idx  <= '0;
        res_moved <= 1'b0;
        if (req_op == pst_pkg::OP_ALLOC) begin
          res_status <= table_full ? pst_pkg::STATUS_FULL : pst_pkg::STATUS_OK;
          res_slot   <= table_full ? '0 : IW'(count);
          res_ent    <= table_full ? '0 : req_ent;
        end else begin
          res_status <= sidx_ok ? pst_pkg::STATUS_OK : pst_pkg::STATUS_FULL;
          res_slot   <= sidx_ok ? IW'(req_sidx) : '0;
          res_ent    <= sidx_ok ? req_ent : '0;
        end
      end
      pst_pkg::ST_SCAN: begin
        if (hit) begin
          hit_idx    <= cmp_idx;
          last_idx   <= IW'(count - 1'b1);
          res_status <= pst_pkg::STATUS_OK;
          res_slot   <= cmp_idx;
          res_moved  <= 1'b0;
          res_ent    <= req_ent;
        end else if (scan_more) begin
          cmp_idx  <= IW'(scan_idx);
          scan_idx <= scan_idx + 1'b1;
        end else if (!cmp_valid) begin
          res_status <= pst_pkg::STATUS_MISS;
          res_slot   <= '0;
          res_moved  <= 1'b0;
          res_ent    <= '0;
        end
      end
      pst_pkg::ST_FREE_MOVE: begin
        res_moved <= hit_idx != last_idx;
        res_ent   <= (hit_idx != last_idx) ? rd_data.entity : pst_pkg::NULL_ENTITY;
      end
      pst_pkg::ST_DONE: begin
        if (out_free) begin
          status         <= res_status;
          result_slot    <= 10'(res_slot);
          moved_valid    <= res_moved;
          moved_entity   <= res_ent;
          active_entries <= 11'(count);
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= SLOT_COUNT)
    else $error("entry count beyond table depth");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == pst_pkg::ST_SCAN) |-> !wr_en)
    else $error("memory write during entity scan");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == pst_pkg::ST_EXEC))
    else $error("accepted request did not start execution");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pst_pkg::STATUS_OK) |->
      (result_slot == '0 && !moved_valid && moved_entity == '0))
    else $error("error result carries slot or entity");

  a_free_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == pst_pkg::ST_FREE_PARK) |=> (count == $past(count) - 1'b1))
    else $error("free did not shrink the table");

endmodule

### rtl/packed_slot_table_top.sv
// packed slot table: dense entity record table with swap-remove free
// alloc and assign pass from EXEC to DONE, where their result is registered
// lookup and free scan the table one slot per cycle through the record memory
// read port; free then does a read and up to two writes for the swap
// one request at a time; a new one is taken while the last result waits
// after reset a clearing pass over all SLOT_COUNT slots holds in_ready low
module packed_slot_table_top #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF,
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] entity_id,
  input  logic [11:0] slot_index,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_z,
  input  logic [7:0]  faction_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  result_slot,
  output logic        moved_valid,
  output logic [31:0] moved_entity,
  output logic [10:0] active_entries,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  pst_pkg::record_t rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  pst_pkg::record_t wr_data;

  pst_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .entity_id      (entity_id),
    .slot_index     (slot_index),
    .pos_x          (pos_x),
    .pos_z          (pos_z),
    .faction_code   (faction_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .result_slot    (result_slot),
    .moved_valid    (moved_valid),
    .moved_entity   (moved_entity),
    .active_entries (active_entries),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  pst_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
